// File: rtl/ctp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and codes for the connection pair table.
// No dependencies.
package ctp_pkg;

	typedef enum logic [2:0] {
		ACT_ADD        = 3'd0,
		ACT_REMOVE     = 3'd1,
		ACT_LOOKUP     = 3'd2,
		ACT_GET_SUBNET = 3'd3,
		ACT_MARK_READY = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_MATCH  = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_READY = 2'd3
	} status_t;

	typedef enum logic {
		CS_IDLE = 1'b0,
		CS_BUSY = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic cap;
		logic exec;
	} ctp_cmd_t;

	typedef struct packed {
		logic full;
		logic hit;
	} ctp_sts_t;

endpackage
`default_nettype wire

// File: rtl/ctp_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Request channel: one table action per word.
// No dependencies.
interface ctp_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [15:0] producer_id;
	logic [15:0] consumer_id;
	logic        direction;
	logic [3:0]  subnet_id;

	modport source (output valid, action, producer_id, consumer_id, direction, subnet_id,
		input ready);
	modport sink (input valid, action, producer_id, consumer_id, direction, subnet_id,
		output ready);
endinterface
`default_nettype wire

// File: rtl/ctp_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Response channel: one result word per request.
// No dependencies.
interface ctp_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  found_subnet;
	logic [15:0] found_producer;
	logic [15:0] found_consumer;
	logic        found_ready;

	modport source (output valid, status, found_subnet, found_producer, found_consumer,
		found_ready, input ready);
	modport sink (input valid, status, found_subnet, found_producer, found_consumer,
		found_ready, output ready);
endinterface
`default_nettype wire

// File: rtl/ctp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Controller: request capture, execute sequencing and result valid.
// Depends on ctp_pkg.
module ctp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  ctp_pkg::ctp_sts_t sts,
	output ctp_pkg::ctp_cmd_t cmd
);
	import ctp_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        can_exec;

	assign can_exec = !out_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (req_valid) begin
					state_d = CS_BUSY;
				end
			end
			CS_BUSY: begin
				if (can_exec) begin
					state_d = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd.cap   = 1'b0;
		cmd.exec  = 1'b0;
		case (state_q)
			CS_IDLE: begin
				req_ready = 1'b1;
				cmd.cap   = req_valid;
			end
			CS_BUSY: begin
				cmd.exec = can_exec;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

	a_exec_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("result word not presented after execute");
	a_busy_drains: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CS_BUSY && !out_valid_q |=> state_q == CS_IDLE)
		else $error("execute stalled with empty output register");
	a_cap_exec_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cap && cmd.exec))
		else $error("capture and execute in the same cycle");
	a_no_cap_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |=> state_q == CS_BUSY && !cmd.cap)
		else $error("second capture before execute");
	a_full_hit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !(sts.full && sts.hit))
		else $error("table full and match reported together");

endmodule
`default_nettype wire

// File: rtl/ctp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// Datapath: request registers, pair table, parallel match and result register.
// Depends on ctp_pkg.
module ctp_datapath #(
	parameter int TABLE_ENTRIES = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctp_pkg::ctp_cmd_t cmd,
	output ctp_pkg::ctp_sts_t sts,
	input  logic [2:0]        action,
	input  logic [15:0]       producer_id,
	input  logic [15:0]       consumer_id,
	input  logic              direction,
	input  logic [3:0]        subnet_id,
	output logic [1:0]        status,
	output logic [3:0]        found_subnet,
	output logic [15:0]       found_producer,
	output logic [15:0]       found_consumer,
	output logic              found_ready
);
	import ctp_pkg::*;

	localparam int IdxW = $clog2(TABLE_ENTRIES);

	logic [2:0]  act_q;
	logic [15:0] prod_q;
	logic [15:0] cons_q;
	logic        dir_q;
	logic [3:0]  sub_q;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TABLE_ENTRIES-1:0] ready_q;
	logic [3:0]  subnet_q   [TABLE_ENTRIES];
	logic        dirn_q     [TABLE_ENTRIES];
	logic [15:0] producer_q [TABLE_ENTRIES];
	logic [15:0] consumer_q [TABLE_ENTRIES];

	logic [TABLE_ENTRIES-1:0] sub_hit;
	logic [TABLE_ENTRIES-1:0] pair_hit;
	logic [IdxW-1:0] sub_idx;
	logic [IdxW-1:0] pair_idx;
	logic [IdxW-1:0] free_idx;
	logic            sub_found;
	logic            pair_found;
	logic            free_found;

	status_t     res_status;
	logic [3:0]  res_subnet;
	logic [15:0] res_producer;
	logic [15:0] res_consumer;
	logic        res_ready;
	logic        do_add;
	logic        do_remove;
	logic        do_mark;

	status_t     status_q;
	logic [3:0]  found_subnet_q;
	logic [15:0] found_producer_q;
	logic [15:0] found_consumer_q;
	logic        found_ready_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			act_q  <= action;
			prod_q <= producer_id;
			cons_q <= consumer_id;
			dir_q  <= direction;
			sub_q  <= subnet_id;
		end
	end

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			sub_hit[i]  = valid_q[i] && subnet_q[i] == sub_q && dirn_q[i] == dir_q;
			pair_hit[i] = valid_q[i] && producer_q[i] == prod_q &&
				consumer_q[i] == cons_q && dirn_q[i] == dir_q;
		end
	end

	// lowest-numbered entry wins
	always_comb begin
		sub_idx    = '0;
		pair_idx   = '0;
		free_idx   = '0;
		sub_found  = 1'b0;
		pair_found = 1'b0;
		free_found = 1'b0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (sub_hit[i]) begin
				sub_idx   = IdxW'(i);
				sub_found = 1'b1;
			end
			if (pair_hit[i]) begin
				pair_idx   = IdxW'(i);
				pair_found = 1'b1;
			end
			if (!valid_q[i]) begin
				free_idx   = IdxW'(i);
				free_found = 1'b1;
			end
		end
	end

	always_comb begin
		res_status   = ST_NO_MATCH;
		res_subnet   = '0;
		res_producer = '0;
		res_consumer = '0;
		res_ready    = 1'b0;
		do_add       = 1'b0;
		do_remove    = 1'b0;
		do_mark      = 1'b0;
		sts.full     = 1'b0;
		sts.hit      = 1'b0;
		case (act_q)
			ACT_ADD: begin
				sts.full = !free_found;
				if (free_found) begin
					do_add       = 1'b1;
					res_status   = ST_OK;
					res_subnet   = sub_q;
					res_producer = prod_q;
					res_consumer = cons_q;
				end else begin
					res_status = ST_FULL;
				end
			end
			ACT_REMOVE, ACT_LOOKUP, ACT_MARK_READY: begin
				sts.hit = sub_found;
				if (sub_found) begin
					res_status   = ST_OK;
					res_subnet   = subnet_q[sub_idx];
					res_producer = producer_q[sub_idx];
					res_consumer = consumer_q[sub_idx];
					res_ready    = ready_q[sub_idx] || act_q == ACT_MARK_READY;
					do_remove    = act_q == ACT_REMOVE;
					do_mark      = act_q == ACT_MARK_READY;
				end
			end
			ACT_GET_SUBNET: begin
				sts.hit = pair_found;
				if (pair_found) begin
					res_producer = producer_q[pair_idx];
					res_consumer = consumer_q[pair_idx];
					res_ready    = ready_q[pair_idx];
					if (ready_q[pair_idx]) begin
						res_status = ST_OK;
						res_subnet = subnet_q[pair_idx];
					end else begin
						res_status = ST_NOT_READY;
					end
				end
			end
			default: begin
				res_status = ST_NO_MATCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ready_q <= '0;
		end else if (cmd.exec) begin
			if (do_add) begin
				valid_q[free_idx] <= 1'b1;
				ready_q[free_idx] <= 1'b0;
			end
			if (do_remove) begin
				valid_q[sub_idx] <= 1'b0;
				ready_q[sub_idx] <= 1'b0;
			end
			if (do_mark) begin
				ready_q[sub_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && do_add) begin
			subnet_q[free_idx]   <= sub_q;
			dirn_q[free_idx]     <= dir_q;
			producer_q[free_idx] <= prod_q;
			consumer_q[free_idx] <= cons_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q         <= res_status;
			found_subnet_q   <= res_subnet;
			found_producer_q <= res_producer;
			found_consumer_q <= res_consumer;
			found_ready_q    <= res_ready;
		end
	end

	assign status         = status_q;
	assign found_subnet   = found_subnet_q;
	assign found_producer = found_producer_q;
	assign found_consumer = found_consumer_q;
	assign found_ready    = found_ready_q;

	a_add_fills_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && act_q == ACT_ADD && !sts.full |=>
		$countones(valid_q) == $past($countones(valid_q)) + 1)
		else $error("add did not claim exactly one entry");
	a_remove_frees_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && act_q == ACT_REMOVE && sts.hit |=>
		$countones(valid_q) + 1 == $past($countones(valid_q)))
		else $error("remove did not free exactly one entry");
	a_ready_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ready_q & ~valid_q) == '0)
		else $error("ready flag set on a free entry");
	a_table_still_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(valid_q) && $stable(ready_q))
		else $error("table changed without execute");

endmodule
`default_nettype wire

// File: rtl/connection_pair_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Connection pair table: associative table of producer/consumer pairs.
// A request word is captured into the request registers, then executed into the output register.
// Execute waits while the output register holds an untaken word; no new request is taken until it runs.
// A new request is taken while the previous result word still waits in the output register.
// Reset: all entries free with ready clear, no result pending; no clearing pass.
// Depends on ctp_pkg, ctp_req_if, ctp_rsp_if, ctp_ctrl, ctp_datapath.
module connection_pair_table #(
	parameter int TABLE_ENTRIES = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	ctp_req_if.sink    req,
	ctp_rsp_if.source  rsp
);
	import ctp_pkg::*;

	ctp_cmd_t cmd;
	ctp_sts_t sts;

	ctp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ctp_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.action         (req.action),
		.producer_id    (req.producer_id),
		.consumer_id    (req.consumer_id),
		.direction      (req.direction),
		.subnet_id      (req.subnet_id),
		.status         (rsp.status),
		.found_subnet   (rsp.found_subnet),
		.found_producer (rsp.found_producer),
		.found_consumer (rsp.found_consumer),
		.found_ready    (rsp.found_ready)
	);

endmodule
`default_nettype wire

// File: test/connection_pair_table_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for connection_pair_table: scripted and random table actions
// checked against a table model or set results. Depends on ctp_pkg, ctp_req_if, ctp_rsp_if, connection_pair_table.
module connection_pair_table_tb;
	import ctp_pkg::*;

	localparam int TABLE_ENTRIES = 6;
	localparam int RANDOM_WORDS = 1400;
	localparam logic [2:0] ACT_UNDEF_FIRST = 3'd5;
	localparam logic [2:0] ACT_UNDEF_LAST = 3'd7;

	typedef struct {
		logic [2:0]  action;
		logic [15:0] producer;
		logic [15:0] consumer;
		logic        direction;
		logic [3:0]  subnet;
	} pair_cmd_t;

	typedef struct {
		status_t     status;
		logic [3:0]  subnet;
		logic [15:0] producer;
		logic [15:0] consumer;
		logic        ready;
	} pair_result_t;

	typedef struct {
		pair_cmd_t    cmd;
		bit           typed;
		pair_result_t res;
	} script_row_t;

	logic clk;
	logic arst_n;

	ctp_req_if req_bus();
	ctp_rsp_if rsp_bus();

	connection_pair_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	bit          tbl_used[TABLE_ENTRIES];
	bit          tbl_ready[TABLE_ENTRIES];
	logic [3:0]  tbl_subnet[TABLE_ENTRIES];
	logic        tbl_dir[TABLE_ENTRIES];
	logic [15:0] tbl_prod[TABLE_ENTRIES];
	logic [15:0] tbl_cons[TABLE_ENTRIES];

	pair_result_t pending_results[$];
	script_row_t  script_q[$];
	int errors = 0;
	int mismatches = 0;
	int words_sent = 0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic pair_result_t entry_view(int idx, status_t st);
		pair_result_t r;
		r.status = st;
		r.subnet = tbl_subnet[idx];
		r.producer = tbl_prod[idx];
		r.consumer = tbl_cons[idx];
		r.ready = tbl_ready[idx];
		return r;
	endfunction

	function automatic int find_by_subnet(logic [3:0] sub, logic dir);
		int hit;
		hit = -1;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
			if (tbl_used[i] && tbl_subnet[i] == sub && tbl_dir[i] == dir)
				hit = i;
		return hit;
	endfunction

	function automatic pair_result_t table_apply(pair_cmd_t c);
		pair_result_t r;
		int hit;
		r.status = ST_NO_MATCH;
		r.subnet = '0;
		r.producer = '0;
		r.consumer = '0;
		r.ready = 1'b0;
		hit = -1;
		case (c.action)
			ACT_ADD: begin
				for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
					if (!tbl_used[i])
						hit = i;
				if (hit < 0) begin
					r.status = ST_FULL;
				end else begin
					tbl_used[hit] = 1'b1;
					tbl_subnet[hit] = c.subnet;
					tbl_dir[hit] = c.direction;
					tbl_prod[hit] = c.producer;
					tbl_cons[hit] = c.consumer;
					tbl_ready[hit] = 1'b0;
					r = entry_view(hit, ST_OK);
				end
			end
			ACT_REMOVE: begin
				hit = find_by_subnet(c.subnet, c.direction);
				if (hit >= 0) begin
					r = entry_view(hit, ST_OK);
					tbl_used[hit] = 1'b0;
					tbl_ready[hit] = 1'b0;
				end
			end
			ACT_LOOKUP: begin
				hit = find_by_subnet(c.subnet, c.direction);
				if (hit >= 0)
					r = entry_view(hit, ST_OK);
			end
			ACT_GET_SUBNET: begin
				for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
					if (tbl_used[i] && tbl_prod[i] == c.producer && tbl_cons[i] == c.consumer
							&& tbl_dir[i] == c.direction)
						hit = i;
				if (hit >= 0) begin
					if (tbl_ready[hit]) begin
						r = entry_view(hit, ST_OK);
					end else begin
						r = entry_view(hit, ST_NOT_READY);
						r.subnet = '0;
					end
				end
			end
			ACT_MARK_READY: begin
				hit = find_by_subnet(c.subnet, c.direction);
				if (hit >= 0) begin
					tbl_ready[hit] = 1'b1;
					r = entry_view(hit, ST_OK);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic pair_cmd_t pick_cmd(int n);
		pair_cmd_t c;
		int live[$];
		int k;
		int roll;
		int add_weight;
		action_t probes[4];
		probes = '{ACT_REMOVE, ACT_LOOKUP, ACT_GET_SUBNET, ACT_MARK_READY};
		c.action = ACT_LOOKUP;
		c.producer = 16'($urandom);
		c.consumer = 16'($urandom);
		c.direction = 1'($urandom_range(0, 1));
		c.subnet = 4'($urandom_range(0, 15));
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (tbl_used[i])
				live.push_back(i);
		// alternate fill-heavy and drain-heavy stretches
		add_weight = ((n / 120) % 2 == 0) ? 45 : 15;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			c.action = 3'($urandom_range(ACT_UNDEF_FIRST, ACT_UNDEF_LAST));
		end else if (roll < 8 + add_weight) begin
			c.action = ACT_ADD;
			if ($urandom_range(0, 1)) begin
				c.producer = 16'($urandom_range(0, 3));
				c.consumer = 16'($urandom_range(0, 3));
			end
			if ($urandom_range(0, 3) != 0)
				c.subnet = 4'($urandom_range(0, 3));
		end else begin
			c.action = probes[$urandom_range(0, 3)];
			if (live.size() > 0 && $urandom_range(0, 9) < 8) begin
				k = live[$urandom_range(0, live.size() - 1)];
				c.direction = tbl_dir[k];
				if (c.action == ACT_GET_SUBNET) begin
					c.producer = tbl_prod[k];
					c.consumer = tbl_cons[k];
					if ($urandom_range(0, 7) == 0)
						c.producer[4'($urandom_range(0, 15))] ^= 1'b1;
				end else begin
					c.subnet = tbl_subnet[k];
				end
			end
		end
		return c;
	endfunction

	task automatic put_row(logic [2:0] act, logic [15:0] prod, logic [15:0] cons, logic dir,
			logic [3:0] sub, bit typed, status_t st, logic [3:0] fsub, logic [15:0] fprod,
			logic [15:0] fcons, logic frdy);
		script_row_t row;
		row.cmd = '{act, prod, cons, dir, sub};
		row.typed = typed;
		row.res = '{st, fsub, fprod, fcons, frdy};
		script_q.push_back(row);
	endtask

	task automatic note_mismatch(pair_result_t want, pair_result_t got, bit stray);
		errors++;
		mismatches++;
		if (mismatches <= 10) begin
			if (stray)
				$display("%0t: result word with nothing pending: st=%0d sub=%0d p=%h c=%h r=%0d",
					$realtime, got.status, got.subnet, got.producer, got.consumer, got.ready);
			else
				$display({"%0t: mismatch exp st=%0d sub=%0d p=%h c=%h r=%0d, ",
					"got st=%0d sub=%0d p=%h c=%h r=%0d"},
					$realtime, want.status, want.subnet, want.producer, want.consumer, want.ready,
					got.status, got.subnet, got.producer, got.consumer, got.ready);
		end
	endtask

	always @(posedge clk) begin : check_results
		pair_result_t want;
		pair_result_t got;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			got.status = status_t'(rsp_bus.status);
			got.subnet = rsp_bus.found_subnet;
			got.producer = rsp_bus.found_producer;
			got.consumer = rsp_bus.found_consumer;
			got.ready = rsp_bus.found_ready;
			if (pending_results.size() == 0) begin
				note_mismatch(got, got, 1'b1);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.subnet !== want.subnet
						|| got.producer !== want.producer || got.consumer !== want.consumer
						|| got.ready !== want.ready)
					note_mismatch(want, got, 1'b0);
			end
		end
	end

	initial begin : drain_results
		int cyc;
		int mode;
		bit hold_a;
		bit hold_b;
		cyc = 0;
		mode = 0;
		hold_a = 0;
		hold_b = 0;
		rsp_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 128 == 0)
				mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else if ((!hold_a && words_sent >= 300) || (!hold_b && words_sent >= 1000)) begin
				if (hold_a)
					hold_b = 1;
				hold_a = 1;
				hold_left = $urandom_range(120, 200);
				rsp_bus.ready <= 1'b0;
			end else begin
				case (mode)
					0: rsp_bus.ready <= 1'b1;
					1: rsp_bus.ready <= 1'($urandom_range(0, 1));
					2: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
					default: rsp_bus.ready <= (cyc % 7 < 4);
				endcase
			end
		end
	end

	initial begin : drive_requests
		pair_cmd_t    cmd;
		pair_result_t res;
		script_row_t  row;
		int total;
		int burst_left;
		req_bus.valid = 1'b0;
		req_bus.action = '0;
		req_bus.producer_id = '0;
		req_bus.consumer_id = '0;
		req_bus.direction = 1'b0;
		req_bus.subnet_id = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tbl_used[i] = 1'b0;
			tbl_ready[i] = 1'b0;
		end

		// empty table, every search misses
		put_row(ACT_LOOKUP, 16'h0000, 16'h0000, 1'b0, 4'd0, 1, ST_NO_MATCH, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_GET_SUBNET, 16'h0000, 16'h0000, 1'b0, 4'd0, 1, ST_NO_MATCH, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_REMOVE, 16'hFFFF, 16'hFFFF, 1'b1, 4'd15, 1, ST_NO_MATCH, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_MARK_READY, 16'h0000, 16'h0000, 1'b0, 4'd3, 1, ST_NO_MATCH, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_UNDEF_LAST, 16'hFFFF, 16'hFFFF, 1'b1, 4'd15, 1, ST_NO_MATCH, 4'd0, 16'h0, 16'h0, 0);
		// field extremes, ready handshake of a pair
		put_row(ACT_ADD, 16'hFFFF, 16'hFFFF, 1'b1, 4'd15, 1, ST_OK, 4'd15, 16'hFFFF, 16'hFFFF, 0);
		put_row(ACT_ADD, 16'h0000, 16'h0000, 1'b0, 4'd0, 1, ST_OK, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_GET_SUBNET, 16'hFFFF, 16'hFFFF, 1'b1, 4'd0, 1, ST_NOT_READY, 4'd0, 16'hFFFF,
			16'hFFFF, 0);
		put_row(ACT_MARK_READY, 16'h0, 16'h0, 1'b1, 4'd15, 1, ST_OK, 4'd15, 16'hFFFF, 16'hFFFF, 1);
		put_row(ACT_GET_SUBNET, 16'hFFFF, 16'hFFFF, 1'b1, 4'd0, 1, ST_OK, 4'd15, 16'hFFFF,
			16'hFFFF, 1);
		put_row(ACT_LOOKUP, 16'h0, 16'h0, 1'b0, 4'd15, 1, ST_NO_MATCH, 4'd0, 16'h0, 16'h0, 0);
		// duplicate subnet and direction, lower entry wins
		put_row(ACT_ADD, 16'h1234, 16'h5678, 1'b1, 4'd15, 0, ST_OK, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_LOOKUP, 16'h0, 16'h0, 1'b1, 4'd15, 0, ST_OK, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_REMOVE, 16'h0, 16'h0, 1'b1, 4'd15, 0, ST_OK, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_LOOKUP, 16'h0, 16'h0, 1'b1, 4'd15, 0, ST_OK, 4'd0, 16'h0, 16'h0, 0);
		// refill the freed entry, then fill up
		put_row(ACT_ADD, 16'hA5A5, 16'h5A5A, 1'b0, 4'd5, 0, ST_OK, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_ADD, 16'h0001, 16'h8000, 1'b0, 4'd6, 0, ST_OK, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_ADD, 16'h7FFF, 16'h0002, 1'b1, 4'd7, 0, ST_OK, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_ADD, 16'h00FF, 16'hFF00, 1'b0, 4'd8, 0, ST_OK, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_ADD, 16'hBEEF, 16'hCAFE, 1'b1, 4'd9, 1, ST_FULL, 4'd0, 16'h0, 16'h0, 0);
		// first pair match not ready while a later duplicate is ready
		put_row(ACT_REMOVE, 16'h0, 16'h0, 1'b0, 4'd6, 0, ST_OK, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_ADD, 16'h0000, 16'h0000, 1'b0, 4'd9, 0, ST_OK, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_MARK_READY, 16'h0, 16'h0, 1'b0, 4'd9, 0, ST_OK, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_GET_SUBNET, 16'h0000, 16'h0000, 1'b0, 4'd0, 0, ST_OK, 4'd0, 16'h0, 16'h0, 0);
		put_row(ACT_UNDEF_FIRST, 16'h0, 16'h0, 1'b0, 4'd9, 1, ST_NO_MATCH, 4'd0, 16'h0, 16'h0, 0);

		total = script_q.size() + RANDOM_WORDS;
		burst_left = $urandom_range(1, 12);
		wait (arst_n === 1'b1);
		@(negedge clk);
		for (int n = 0; n < total; n++) begin
			if (n < script_q.size()) begin
				row = script_q[n];
			end else begin
				row.cmd = pick_cmd(n);
				row.typed = 0;
			end
			cmd = row.cmd;
			req_bus.valid <= 1'b1;
			req_bus.action <= cmd.action;
			req_bus.producer_id <= cmd.producer;
			req_bus.consumer_id <= cmd.consumer;
			req_bus.direction <= cmd.direction;
			req_bus.subnet_id <= cmd.subnet;
			do @(posedge clk); while (req_bus.ready !== 1'b1);
			res = table_apply(cmd);
			pending_results.push_back(row.typed ? row.res : res);
			words_sent++;
			@(negedge clk);
			if (burst_left > 0)
				burst_left--;
			// keep offering while the receiver holds off
			if (burst_left == 0 && hold_left == 0 && n != total - 1) begin
				req_bus.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
					: $urandom_range(1, 12);
			end
		end
		req_bus.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		errors += pending_results.size();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/ctp_pkg.sv
rtl/ctp_req_if.sv
rtl/ctp_rsp_if.sv
rtl/ctp_ctrl.sv
rtl/ctp_datapath.sv
rtl/connection_pair_table.sv
test/connection_pair_table_tb.sv
